FILE: rtl/ppi_pkg.sv
// ----------------------------------------------------------------------------
// ppi_pkg - shared definitions of the peak-to-peak impedance unit
// Widths, register indexes, reset values and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package ppi_pkg;

    localparam int MAX_CHANNELS = 16;
    localparam int SAMPLE_W     = 24;
    localparam int CH_W         = 4;    // channel index
    localparam int CNT_W        = 5;    // channel count, holds MAX_CHANNELS
    localparam int OPC_W        = 32;   // ohms per code, Q16.16
    localparam int SR_W         = 16;   // series resistance
    localparam int IMP_W        = 32;   // impedance result
    localparam int PROD_W       = SAMPLE_W + OPC_W;
    localparam int FRAC_W       = 16;
    localparam int DIFF_W       = PROD_W - FRAC_W + 1;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;
    localparam int OUT_TDATA_W  = 40;   // channel + impedance, padded to bytes

    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OHMS_PER_CODE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SERIES_RESISTANCE = 2'd2;

    localparam logic [CNT_W-1:0] RST_CHANNEL_COUNT     = 5'd8;
    localparam logic [OPC_W-1:0] RST_OHMS_PER_CODE     = 32'd122070;
    localparam logic [SR_W-1:0]  RST_SERIES_RESISTANCE = 16'd2200;

    localparam logic [IMP_W-1:0] IMP_MAX = 32'h7FFF_FFFF;

    typedef struct packed {
        logic fold;         // fold the accepted sample into its channel
        logic ch_clear;     // restart the emission channel counter
        logic ch_inc;       // advance to the next emission channel
        logic load_prod;    // register peak-to-peak times ohms per code
        logic load_result;  // register the saturated result
        logic clear;        // drop all peaks and the position
    } ppi_cmd_t;

    typedef struct packed {
        logic last_ch;      // emission channel is the final active one
    } ppi_status_t;

endpackage

FILE: rtl/ppi_ctrl.sv
// ----------------------------------------------------------------------------
// ppi_ctrl - sequencer of the peak-to-peak impedance unit
// Accepts samples and steps the per-channel emission at buffer end.
// ----------------------------------------------------------------------------
module ppi_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tlast,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  ppi_pkg::ppi_status_t status,
    output ppi_pkg::ppi_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_ACCUM = 4'b0001,
        ST_MUL   = 4'b0010,
        ST_SUB   = 4'b0100,
        ST_SEND  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   take;

    assign s_tready = (state_reg == ST_ACCUM);
    assign m_tvalid = (state_reg == ST_SEND);
    assign take     = s_tvalid && s_tready;

    always_comb begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.fold        = take;
        cmd.load_prod   = (state_reg == ST_MUL);
        cmd.load_result = (state_reg == ST_SUB);
        case (state_reg)
            ST_ACCUM: begin
                if (take && s_tlast) begin
                    cmd.ch_clear = 1'b1;
                    state_next   = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_SUB;
            end
            ST_SUB: begin
                state_next = ST_SEND;
            end
            ST_SEND: begin
                if (m_tready) begin
                    if (status.last_ch) begin
                        cmd.clear  = 1'b1;
                        state_next = ST_ACCUM;
                    end else begin
                        cmd.ch_inc = 1'b1;
                        state_next = ST_MUL;
                    end
                end
            end
            default: begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACCUM;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/ppi_datapath.sv
// ----------------------------------------------------------------------------
// ppi_datapath - peak stores, configuration and impedance arithmetic
// Running max/min per channel, multiply, shift, subtract and saturate.
// ----------------------------------------------------------------------------
module ppi_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    input  logic [ppi_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ppi_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic [ppi_pkg::SAMPLE_W-1:0]         sample,
    input  ppi_pkg::ppi_cmd_t                    cmd,
    output ppi_pkg::ppi_status_t                 status,
    output logic [ppi_pkg::OUT_TDATA_W-1:0]      out_data,
    output logic                                 out_last
);

    // configuration
    logic [ppi_pkg::CNT_W-1:0] cc_reg;
    logic [ppi_pkg::OPC_W-1:0] opc_reg;
    logic [ppi_pkg::SR_W-1:0]  sr_reg;

    // peak stores; an entry without its valid bit reads as zero
    logic signed [ppi_pkg::SAMPLE_W-1:0] hi_mem [ppi_pkg::MAX_CHANNELS];
    logic signed [ppi_pkg::SAMPLE_W-1:0] lo_mem [ppi_pkg::MAX_CHANNELS];
    logic [ppi_pkg::MAX_CHANNELS-1:0]    valid_reg;

    logic [ppi_pkg::CH_W-1:0]   pos_reg;
    logic [ppi_pkg::CH_W-1:0]   pos_next;
    logic [ppi_pkg::CH_W-1:0]   pos_eff;
    logic [ppi_pkg::CNT_W-1:0]  pos_inc;
    logic [ppi_pkg::CH_W-1:0]   ch_reg;
    logic [ppi_pkg::CNT_W-1:0]  n_act;
    logic [ppi_pkg::CH_W-1:0]   addr;

    logic signed [ppi_pkg::SAMPLE_W-1:0] rd_hi;
    logic signed [ppi_pkg::SAMPLE_W-1:0] rd_lo;
    logic signed [ppi_pkg::SAMPLE_W-1:0] s_val;
    logic signed [ppi_pkg::SAMPLE_W-1:0] new_hi;
    logic signed [ppi_pkg::SAMPLE_W-1:0] new_lo;
    logic signed [ppi_pkg::SAMPLE_W:0]   pp_wide;
    logic [ppi_pkg::SAMPLE_W-1:0]        pp;

    logic [ppi_pkg::PROD_W-1:0]  prod_next;
    logic [ppi_pkg::PROD_W-1:0]  prod_reg;
    logic [ppi_pkg::DIFF_W-1:0]  diff;
    logic                        ovf;
    logic [ppi_pkg::IMP_W-1:0]   imp;
    logic [ppi_pkg::OUT_TDATA_W-1:0] out_data_reg;
    logic                        out_last_reg;

    // zero means one channel, above the store depth means all of it
    always_comb begin
        if (cc_reg == '0) begin
            n_act = ppi_pkg::CNT_W'(1);
        end else if (cc_reg > ppi_pkg::CNT_W'(ppi_pkg::MAX_CHANNELS)) begin
            n_act = ppi_pkg::CNT_W'(ppi_pkg::MAX_CHANNELS);
        end else begin
            n_act = cc_reg;
        end
    end

    // count lowered mid-buffer: wrap before storing
    assign pos_eff  = ({1'b0, pos_reg} >= n_act) ? '0 : pos_reg;
    assign pos_inc  = {1'b0, pos_eff} + ppi_pkg::CNT_W'(1);
    assign pos_next = (pos_inc >= n_act) ? '0 : pos_inc[ppi_pkg::CH_W-1:0];

    assign addr  = cmd.load_prod ? ch_reg : pos_eff;
    assign rd_hi = valid_reg[addr] ? hi_mem[addr] : '0;
    assign rd_lo = valid_reg[addr] ? lo_mem[addr] : '0;
    assign s_val = $signed(sample);

    assign new_hi = (s_val > rd_hi) ? s_val : rd_hi;
    assign new_lo = (s_val < rd_lo) ? s_val : rd_lo;

    // max never below zero, min never above: the difference is non-negative
    assign pp_wide   = {rd_hi[ppi_pkg::SAMPLE_W-1], rd_hi} - {rd_lo[ppi_pkg::SAMPLE_W-1], rd_lo};
    assign pp        = pp_wide[ppi_pkg::SAMPLE_W-1:0];
    assign prod_next = pp * opc_reg;

    assign diff = {1'b0, prod_reg[ppi_pkg::PROD_W-1:ppi_pkg::FRAC_W]}
                - ppi_pkg::DIFF_W'(sr_reg);
    assign ovf  = !diff[ppi_pkg::DIFF_W-1] && (|diff[ppi_pkg::DIFF_W-2:ppi_pkg::IMP_W-1]);
    assign imp  = ovf ? ppi_pkg::IMP_MAX : diff[ppi_pkg::IMP_W-1:0];

    assign status.last_ch = (({1'b0, ch_reg} + ppi_pkg::CNT_W'(1)) == n_act);
    assign out_data       = out_data_reg;
    assign out_last       = out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cc_reg <= ppi_pkg::RST_CHANNEL_COUNT;
            opc_reg <= ppi_pkg::RST_OHMS_PER_CODE;
            sr_reg <= ppi_pkg::RST_SERIES_RESISTANCE;
        end else if (cfg_valid) begin
            case (cfg_index)
                ppi_pkg::REG_CHANNEL_COUNT: begin
                    cc_reg <= cfg_data[ppi_pkg::CNT_W-1:0];
                end
                ppi_pkg::REG_OHMS_PER_CODE: begin
                    opc_reg <= cfg_data[ppi_pkg::OPC_W-1:0];
                end
                ppi_pkg::REG_SERIES_RESISTANCE: begin
                    sr_reg <= cfg_data[ppi_pkg::SR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            pos_reg   <= '0;
            ch_reg    <= '0;
        end else begin
            if (cmd.clear) begin
                valid_reg <= '0;
                pos_reg   <= '0;
            end else if (cmd.fold) begin
                valid_reg[pos_eff] <= 1'b1;
                pos_reg            <= pos_next;
            end
            if (cmd.ch_clear) begin
                ch_reg <= '0;
            end else if (cmd.ch_inc) begin
                ch_reg <= ch_reg + ppi_pkg::CH_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fold) begin
            hi_mem[pos_eff] <= new_hi;
            lo_mem[pos_eff] <= new_lo;
        end
        if (cmd.load_prod) begin
            prod_reg <= prod_next;
        end
        if (cmd.load_result) begin
            out_data_reg <= {(ppi_pkg::OUT_TDATA_W - ppi_pkg::IMP_W - ppi_pkg::CH_W)'(0),
                             imp, ch_reg};
            out_last_reg <= status.last_ch;
        end
    end

endmodule

FILE: rtl/peak_to_peak_impedance_unit.sv
// ----------------------------------------------------------------------------
// peak_to_peak_impedance_unit - lead-off impedance from peak-to-peak amplitude
// Tracks per-channel max/min of interleaved samples and reports one
// impedance per channel at the end of each buffer.
// ----------------------------------------------------------------------------
// Feed interleaved samples, channel 0 first, one request per cycle; the
// channel position wraps at channel_count (0 counts as 1, above 16 as 16).
// An ordinary sample is folded into its channel as it is accepted. The
// sample flagged with tlast is folded in and then starts the report: for
// each active channel the sequencer registers the 24x32 multiply (MUL),
// then shifts, subtracts and saturates into the result register (SUB),
// and then holds the result on m_ until taken; during the report, output
// stalls included, no sample is taken. After the final result (tlast high)
// all peaks and the position restart at zero. Configuration writes are
// always ready; write them only while the unit is between buffers.
// ----------------------------------------------------------------------------
module peak_to_peak_impedance_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ppi_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ppi_pkg::CFG_DATA_W-1:0]       cfg_data,
    // sample input
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [ppi_pkg::SAMPLE_W-1:0]         s_tdata,   // [23:0] sample
    input  logic                                 s_tlast,   // last sample of buffer
    // impedance results
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [ppi_pkg::OUT_TDATA_W-1:0]      m_tdata,   // [3:0] channel,
                                                            // [35:4] impedance_ohms,
                                                            // [39:36] zero
    output logic                                 m_tlast    // result of final channel
);

    ppi_pkg::ppi_cmd_t    cmd;
    ppi_pkg::ppi_status_t status;

    // registers take a write in any cycle
    assign cfg_ready = 1'b1;

    // sequence sample folding and the per-channel report
    ppi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // hold peaks and configuration, compute and register each result
    ppi_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

FILE: test/ppi_report_checker.sv
// ----------------------------------------------------------------------------
// ppi_report_checker - impedance report predictor and comparator
// Watches the register, sample and result channels of the unit. It keeps
// its own per-channel peak stores and settings, queues the impedance
// report that each buffer-ending sample calls for, and compares every
// accepted result with the oldest queued one.
// ----------------------------------------------------------------------------
module ppi_report_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [ppi_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ppi_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 s_tvalid,
    input  logic                                 s_tready,
    input  logic [ppi_pkg::SAMPLE_W-1:0]         s_tdata,   // [23:0] sample
    input  logic                                 s_tlast,
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic [ppi_pkg::OUT_TDATA_W-1:0]      m_tdata,   // [3:0] channel,
                                                            // [35:4] impedance_ohms,
                                                            // [39:36] zero
    input  logic                                 m_tlast,
    output int                                   mismatch_count,
    output int                                   results_due
);
    import ppi_pkg::*;

    localparam int REPORT_CAP = 40;

    typedef struct packed {
        logic [CH_W-1:0]         channel;
        logic signed [IMP_W-1:0] ohms;
        logic                    final_ch;
    } impedance_result_t;

    impedance_result_t          expected_impedance_q[$];
    logic signed [SAMPLE_W-1:0] ch_max [MAX_CHANNELS];
    logic signed [SAMPLE_W-1:0] ch_min [MAX_CHANNELS];
    int unsigned                slot;
    logic [CNT_W-1:0]           count_reg;
    logic [OPC_W-1:0]           gain_reg;
    logic [SR_W-1:0]            series_reg;

    // 0 counts as one channel, anything above the store depth as all of it
    function automatic int unsigned live_channels();
        int unsigned n;
        n = count_reg;
        if (n == 0) n = 1;
        if (n > MAX_CHANNELS) n = MAX_CHANNELS;
        return n;
    endfunction

    function automatic logic signed [IMP_W-1:0] ohms_for(input int unsigned ch);
        longint swing;
        longint gain;
        longint series;
        longint scaled;
        longint ceiling;
        swing   = longint'(ch_max[ch]) - longint'(ch_min[ch]);
        gain    = gain_reg;
        series  = series_reg;
        ceiling = IMP_MAX;
        // swing is never negative, so the arithmetic shift is a floor
        scaled  = ((swing * gain) >>> FRAC_W) - series;
        if (scaled > ceiling) scaled = ceiling;
        if (scaled < -ceiling - 1) scaled = -ceiling - 1;
        return scaled[IMP_W-1:0];
    endfunction

    task automatic clear_peaks();
        for (int i = 0; i < MAX_CHANNELS; i++) begin
            ch_max[i] = '0;
            ch_min[i] = '0;
        end
        slot = 0;
    endtask

    task automatic flag_mismatch(input string what, input longint want, input longint got);
        mismatch_count++;
        if (mismatch_count <= REPORT_CAP)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    endtask

    always @(posedge aclk) begin : track
        logic signed [SAMPLE_W-1:0] code;
        logic signed [IMP_W-1:0]    got_ohms;
        int unsigned                n;
        impedance_result_t          want;
        if (!aresetn) begin
            count_reg      = RST_CHANNEL_COUNT;
            gain_reg       = RST_OHMS_PER_CODE;
            series_reg     = RST_SERIES_RESISTANCE;
            mismatch_count = 0;
            clear_peaks();
            expected_impedance_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_CHANNEL_COUNT:     count_reg  = cfg_data[CNT_W-1:0];
                    REG_OHMS_PER_CODE:     gain_reg   = cfg_data[OPC_W-1:0];
                    REG_SERIES_RESISTANCE: series_reg = cfg_data[SR_W-1:0];
                    default: ;  // unused index, drop the write
                endcase
            end

            if (s_tvalid && s_tready) begin
                n    = live_channels();
                code = s_tdata[SAMPLE_W-1:0];
                // count lowered mid-buffer: wrap before folding in
                if (slot >= n) slot = 0;
                if (code > ch_max[slot]) ch_max[slot] = code;
                if (code < ch_min[slot]) ch_min[slot] = code;
                slot++;
                if (slot >= n) slot = 0;
                if (s_tlast) begin
                    for (int unsigned ch = 0; ch < n; ch++) begin
                        want.channel  = ch[CH_W-1:0];
                        want.ohms     = ohms_for(ch);
                        want.final_ch = (ch + 1 == n);
                        expected_impedance_q.push_back(want);
                    end
                    clear_peaks();
                end
            end

            if (m_tvalid && m_tready) begin
                got_ohms = m_tdata[CH_W +: IMP_W];
                if (expected_impedance_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_CAP)
                        $display("%0t: unexpected result, channel %0d, impedance %0d",
                                 $time, m_tdata[CH_W-1:0], got_ohms);
                end else begin
                    want = expected_impedance_q.pop_front();
                    if (m_tdata[CH_W-1:0] !== want.channel)
                        flag_mismatch("channel", want.channel, m_tdata[CH_W-1:0]);
                    if (got_ohms !== want.ohms)
                        flag_mismatch("impedance_ohms", want.ohms, got_ohms);
                    if (m_tlast !== want.final_ch)
                        flag_mismatch("last_result", want.final_ch, m_tlast);
                    if (m_tdata[OUT_TDATA_W-1:CH_W+IMP_W] !== '0)
                        flag_mismatch("tdata padding", 0, m_tdata[OUT_TDATA_W-1:CH_W+IMP_W]);
                end
            end
        end
        results_due = expected_impedance_q.size();
    end

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - stimulus and verdict for the peak-to-peak impedance unit
// Drives register writes and interleaved sample buffers with random pacing
// on both streams, lets the report checker predict and compare every
// impedance result, and ends on a quiet-cycle watchdog or a verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import ppi_pkg::*;

    localparam int RANDOM_ITEMS  = 285;
    localparam int SETTLE_CYCLES = 8;     // slack after the last result for the clear to land
    localparam int LONG_HOLD     = 400;   // one long result back-pressure
    localparam int STALL_LIMIT   = 4000;  // cycles with no request accepted
    localparam int HOLD_PHASE    = 0;

    // index 3 maps to no register; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam logic [SAMPLE_W-1:0] CODE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] CODE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [SAMPLE_W-1:0]     s_tdata;   // [23:0] sample
    logic                    s_tlast;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_TDATA_W-1:0]  m_tdata;   // [3:0] channel, [35:4] impedance_ohms, [39:36] zero
    logic                    m_tlast;

    int   mismatch_count;
    int   results_due;
    logic hold_start;      // asks the result sink for its one long hold-off
    int   random_items;
    int   send_run;
    bit   send_quiet;

    peak_to_peak_impedance_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    ppi_report_checker i_report_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Pacing shared by both streams: runs of items either with no gaps at
    // all or with a fresh 0..15 cycle gap per request.
    function automatic int draw_gap(inout int run_left, inout bit quiet);
        if (run_left == 0) begin
            run_left = $urandom_range(4, 24);
            quiet    = ($urandom_range(0, 3) == 0);
        end
        run_left--;
        return quiet ? 0 : $urandom_range(0, 15);
    endfunction

    // Mostly full-range codes, with rails and values near zero mixed in.
    function automatic logic [SAMPLE_W-1:0] draw_code();
        logic [31:0] r;
        int          near_zero;
        r         = $urandom();
        near_zero = int'($urandom_range(0, 2000)) - 1000;
        case ($urandom_range(0, 9))
            0:       return CODE_MAX;
            1:       return CODE_MIN;
            2, 3:    return near_zero[SAMPLE_W-1:0];
            default: return r[SAMPLE_W-1:0];
        endcase
    endfunction

    // Result sink: stall each request for a drawn gap; take the one long
    // hold-off when asked so the unit backs up into its sample input.
    initial begin : result_sink
        int gap;
        int run_left;
        bit quiet;
        bit hold_done;
        m_tready  = 1'b0;
        run_left  = 0;
        quiet     = 1'b0;
        hold_done = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (hold_start && !hold_done) begin
                gap       = LONG_HOLD;
                hold_done = 1'b1;
            end else begin
                gap = draw_gap(run_left, quiet);
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    // Watchdog: fail when no request moves on any channel for too long.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                    || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("** peak_to_peak_impedance_unit: FAILED **");
        $finish;
    end

    // Leaves cfg_valid high; callers drop it once their writes are done.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
    endtask

    // Write all registers; the unused index goes last so any aliasing would
    // corrupt the settings the next buffer is checked against.
    task automatic load_settings(input logic [CFG_DATA_W-1:0] count_word,
                                 input logic [CFG_DATA_W-1:0] gain_word,
                                 input logic [CFG_DATA_W-1:0] series_word);
        write_register(REG_CHANNEL_COUNT, count_word);
        write_register(REG_OHMS_PER_CODE, gain_word);
        write_register(REG_SERIES_RESISTANCE, series_word);
        write_register(REG_UNUSED, $urandom());
        cfg_valid <= 1'b0;
    endtask

    // Leaves s_tvalid high; the next push or settle_idle follows in the
    // same time step, so no request is offered twice.
    task automatic push_sample(input logic [SAMPLE_W-1:0] code, input logic last);
        int gap;
        gap = draw_gap(send_run, send_quiet);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= code;
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
    endtask

    // Drop the sample stream and hold until every queued result has come
    // back, then give the unit time to finish clearing.
    task automatic settle_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (results_due != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Mostly whole frames; now and then a ragged length so frames break off
    // mid-way. Every buffer ends on a flagged sample.
    task automatic send_buffer(input int unsigned lanes);
        int unsigned len;
        if ($urandom_range(0, 4) != 0)
            len = lanes * $urandom_range(1, 3);
        else
            len = $urandom_range(1, 3 * lanes);
        for (int unsigned k = 1; k <= len; k++)
            push_sample(draw_code(), k == len);
        random_items += len;
    endtask

    initial begin : stimulus
        logic [31:0]    r;
        logic [CNT_W-1:0] cnt;
        logic [31:0]    gain;
        logic [SR_W-1:0] series;
        int unsigned    lanes;
        int unsigned    buffers;
        int             phase;

        aresetn      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        hold_start   = 1'b0;
        random_items = 0;
        send_run     = 0;
        send_quiet   = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: eight channels, rails on channels 0 and 1.
        push_sample(CODE_MAX, 1'b0);
        push_sample(CODE_MIN, 1'b0);
        push_sample('0, 1'b0);
        push_sample('1, 1'b0);
        push_sample(24'd1, 1'b0);
        push_sample(24'd4096, 1'b0);
        push_sample(-24'sd4096, 1'b0);
        push_sample(24'd123456, 1'b1);

        // Full-scale swing times maximum gain: saturate high.
        settle_idle();
        load_settings(32'd2, 32'hFFFF_FFFF, 32'd0);
        push_sample(CODE_MAX, 1'b0);
        push_sample(CODE_MIN, 1'b0);
        push_sample(CODE_MIN, 1'b0);
        push_sample('0, 1'b1);

        // Zero gain, largest series resistor: most negative result.
        settle_idle();
        load_settings(32'd1, 32'd0, 32'd65535);
        push_sample(CODE_MAX, 1'b1);

        // Channel count zero behaves as one channel.
        settle_idle();
        load_settings(32'd0, 32'd122070, 32'd2200);
        push_sample(24'd5, 1'b0);
        push_sample(-24'sd7, 1'b1);

        // Count above the store depth behaves as 16; a lone flagged sample
        // reports every channel.
        settle_idle();
        load_settings(32'd31, 32'd65536, 32'd1);
        push_sample(-24'sd3, 1'b1);

        // Lower the count mid-buffer: the position wraps before the fold.
        settle_idle();
        load_settings(32'd4, 32'd65536, 32'd0);
        push_sample(24'd10, 1'b0);
        push_sample(24'd20, 1'b0);
        push_sample(24'd30, 1'b0);
        settle_idle();
        write_register(REG_CHANNEL_COUNT, 32'd2);
        cfg_valid <= 1'b0;
        push_sample(-24'sd40, 1'b1);

        // Random phases: fresh settings, then a few buffers each.
        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            settle_idle();
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: cnt = CNT_W'($urandom_range(1, 4));
                5, 6:          cnt = CNT_W'($urandom_range(5, 15));
                7:             cnt = CNT_W'(MAX_CHANNELS);
                default:       cnt = CNT_W'($urandom_range(0, 31));
            endcase
            case ($urandom_range(0, 7))
                0:       gain = '0;
                1:       gain = 32'hFFFF_FFFF;
                2, 3:    gain = $urandom();
                default: gain = $urandom_range(20000, 400000);
            endcase
            case ($urandom_range(0, 5))
                0:       series = '0;
                1:       series = '1;
                default: series = SR_W'($urandom_range(0, 65535));
            endcase
            buffers = $urandom_range(1, 4);
            if (phase == HOLD_PHASE) begin
                // long result hold-off while the sender keeps offering
                cnt        = 4;
                buffers    = 3;
                hold_start <= 1'b1;
            end
            r = $urandom();
            load_settings({r[31:CNT_W], cnt}, gain, {r[31:SR_W], series});
            lanes = (cnt == 0) ? 1 : ((cnt > MAX_CHANNELS) ? MAX_CHANNELS : cnt);
            repeat (buffers) send_buffer(lanes);
            phase++;
        end

        settle_idle();
        if (mismatch_count == 0)
            $display("** peak_to_peak_impedance_unit: PASSED **");
        else
            $display("** peak_to_peak_impedance_unit: FAILED **");
        $finish;
    end

endmodule

FILE: peak_to_peak_impedance_unit.f
rtl/ppi_pkg.sv
rtl/ppi_ctrl.sv
rtl/ppi_datapath.sv
rtl/peak_to_peak_impedance_unit.sv
test/ppi_report_checker.sv
test/tb_top.sv
